// ===== src/pddq_pkg.sv =====
package pddq_pkg;

   localparam logic [1:0] MODE_ARRIVE   = 2'd0;
   localparam logic [1:0] MODE_READ     = 2'd1;
   localparam logic [1:0] MODE_FLUSH    = 2'd2;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   localparam logic [2:0] ST_QUEUED    = 3'd0;
   localparam logic [2:0] ST_DROPPED   = 3'd1;
   localparam logic [2:0] ST_DELIVERED = 3'd2;
   localparam logic [2:0] ST_TRUNCATED = 3'd3;
   localparam logic [2:0] ST_BLOCK     = 3'd4;
   localparam logic [2:0] ST_FLUSHED   = 3'd5;
   localparam logic [2:0] ST_BYPASS    = 3'd6;

   localparam logic CSR_LAG  = 1'b0;
   localparam logic CSR_DROP = 1'b1;

   localparam logic [6:0] MAX_DROP = 7'd100;

   // The ring wraps by address overflow, so the depth must stay a power of two.
   localparam int QUEUE_DEPTH = 1024;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] now_ms;
      logic [3:0]  channel_id;
      logic [15:0] packet_length;
      logic [31:0] sender_tag;
      logic [6:0]  drop_roll;
      logic [15:0] read_capacity;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  slot;
      logic [15:0] copied_length;
      logic [15:0] full_length;
      logic [31:0] sender_tag_out;
      logic [10:0] evicted_count;
      logic        queue_nonempty;
   } rsp_type;

   typedef struct packed {
      logic [31:0] arrival;
      logic [3:0]  channel;
      logic [15:0] length;
      logic [31:0] sender;
   } entry_type;

endpackage

// ===== src/pddq_store.sv =====
module pddq_store #(
   parameter int ADDR_W = 10
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  pddq_pkg::entry_type   wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output pddq_pkg::entry_type   rd_data
);

   pddq_pkg::entry_type mem [2**ADDR_W];
   pddq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/packet_delay_drop_queue.sv =====
// Packet delay and drop queue.
// Requests come in on req_valid/req_stall carrying a req_type: mode 0 stores
// an arriving packet descriptor (or drops it by the roll), mode 1 reads the
// oldest due packet of a channel, mode 2 flushes. Each request gives exactly
// one response on rsp_valid/rsp_stall. Registers lag_ms (index 0) and
// drop_percent (index 1) are written through csr_write/csr_index/csr_data.
// One request is handled at a time; req_stall is high while it is at work
// and while its response waits. An arrival evicts the oldest entry while
// the queue is full or over the byte limit; each eviction reads the length
// of the oldest entry through the single memory read port. A read scans
// entries in arrival order and after a hit moves every younger entry down
// one slot. The memory read port is the bottleneck. After a response is
// taken, the block returns to idle before it takes the next request.
// Reset empties the queue by clearing the pointers and count and sets both
// registers to zero; entry storage itself is not cleared. While the
// receiver stalls, the response holds and no new request is taken.
module packet_delay_drop_queue #(
   parameter int BYTE_LIMIT  = 4194304,
   parameter int MAX_PACKET  = 65535,
   parameter int CHANNELS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pddq_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pddq_pkg::rsp_type   rsp_data,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [9:0]          csr_data
);

   localparam int AW = $clog2(pddq_pkg::QUEUE_DEPTH);
   localparam int CW = AW + 1;
   localparam int BW = $clog2(BYTE_LIMIT + 65536) + 1;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_EVRD   = 4'd1;
   localparam logic [3:0] S_EVCHK  = 4'd2;
   localparam logic [3:0] S_STORE  = 4'd3;
   localparam logic [3:0] S_SCRD   = 4'd4;
   localparam logic [3:0] S_SCCHK  = 4'd5;
   localparam logic [3:0] S_MVRD   = 4'd6;
   localparam logic [3:0] S_MVWR   = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;
   localparam logic [3:0] S_RESP   = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic [AW-1:0]       oldest_ff, oldest_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [BW-1:0]       bytes_ff, bytes_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [9:0]          lag_ff;
   logic [6:0]          drop_ff;
   pddq_pkg::req_type   req_ff, req_in;
   pddq_pkg::rsp_type   rsp_ff, rsp_in;
   logic [15:0]         len_ff, len_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   pddq_pkg::entry_type wr_data, rd_data;

   logic [6:0]          drop_eff;
   logic [31:0]         diff;
   logic [15:0]         len_sat;
   logic [BW-1:0]       bytes_sum;

   pddq_store #(.ADDR_W(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign drop_eff  = (drop_ff > pddq_pkg::MAX_DROP) ? pddq_pkg::MAX_DROP : drop_ff;
   assign len_sat   = (32'(req_data.packet_length) > 32'(MAX_PACKET))
                      ? 16'(MAX_PACKET) : req_data.packet_length;
   assign diff      = req_ff.now_ms - rd_data.arrival - 32'(lag_ff);
   assign bytes_sum = bytes_ff + BW'(len_ff);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lag_ff  <= '0;
         drop_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == pddq_pkg::CSR_LAG) begin
            lag_ff <= csr_data;
         end else begin
            drop_ff <= csr_data[6:0];
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      oldest_in = oldest_ff;
      count_in  = count_ff;
      bytes_in  = bytes_ff;
      idx_in    = idx_ff;
      req_in    = req_ff;
      rsp_in    = rsp_ff;
      len_in    = len_ff;
      wr_en     = 1'b0;
      wr_addr   = oldest_ff + idx_ff[AW-1:0];
      wr_data   = '{arrival: req_ff.now_ms, channel: req_ff.channel_id,
                    length: len_ff, sender: req_ff.sender_tag};
      rd_addr   = oldest_ff + idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               len_in = len_sat;
               idx_in = '0;
               rsp_in = '0;
               rsp_in.status = pddq_pkg::ST_BYPASS;
               state_in = S_DONE;
               if (req_data.mode == pddq_pkg::MODE_FLUSH) begin
                  oldest_in = '0;
                  count_in  = '0;
                  bytes_in  = '0;
                  rsp_in.status = pddq_pkg::ST_FLUSHED;
               end else if (req_data.mode == pddq_pkg::MODE_RESERVED) begin
                  rsp_in.status = pddq_pkg::ST_BYPASS;
               end else if (lag_ff == '0 && drop_eff == '0) begin
                  oldest_in = '0;
                  count_in  = '0;
                  bytes_in  = '0;
               end else if (32'(req_data.channel_id) >= 32'(CHANNELS)) begin
                  rsp_in.status = pddq_pkg::ST_BYPASS;
               end else if (req_data.mode == pddq_pkg::MODE_ARRIVE) begin
                  if (len_sat == '0 || (drop_eff != '0 && req_data.drop_roll <= drop_eff)) begin
                     rsp_in.status = pddq_pkg::ST_DROPPED;
                  end else begin
                     state_in = S_EVRD;
                  end
               end else begin
                  rsp_in.status = pddq_pkg::ST_BLOCK;
                  state_in = S_SCRD;
               end
            end
         end
         S_EVRD: begin
            // When an eviction is needed, the oldest entry's length is fetched here and subtracted in S_EVCHK.
            if (count_ff != '0 && (count_ff >= CW'(pddq_pkg::QUEUE_DEPTH)
                  || bytes_sum > BW'(BYTE_LIMIT))) begin
               rd_addr  = oldest_ff;
               state_in = S_EVCHK;
            end else begin
               state_in = S_STORE;
            end
         end
         S_EVCHK: begin
            bytes_in  = bytes_ff - BW'(rd_data.length);
            oldest_in = oldest_ff + AW'(1);
            count_in  = count_ff - CW'(1);
            rsp_in.evicted_count = rsp_ff.evicted_count + 11'd1;
            state_in  = S_EVRD;
         end
         S_STORE: begin
            wr_en    = 1'b1;
            wr_addr  = oldest_ff + count_ff[AW-1:0];
            count_in = count_ff + CW'(1);
            bytes_in = bytes_sum;
            rsp_in.slot   = 10'(oldest_ff + count_ff[AW-1:0]);
            rsp_in.status = pddq_pkg::ST_QUEUED;
            state_in = S_DONE;
         end
         S_SCRD: begin
            if (idx_ff < count_ff) begin
               state_in = S_SCCHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCCHK: begin
            if (rd_data.channel == req_ff.channel_id && !diff[31]) begin
               rsp_in.slot           = 10'(oldest_ff + idx_ff[AW-1:0]);
               rsp_in.full_length    = rd_data.length;
               rsp_in.sender_tag_out = rd_data.sender;
               rsp_in.copied_length  = (rd_data.length < req_ff.read_capacity)
                                       ? rd_data.length : req_ff.read_capacity;
               rsp_in.status         = (req_ff.read_capacity < rd_data.length)
                                       ? pddq_pkg::ST_TRUNCATED : pddq_pkg::ST_DELIVERED;
               bytes_in = bytes_ff - BW'(rd_data.length);
               state_in = S_MVRD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SCRD;
            end
         end
         S_MVRD: begin
            // Younger entries slide down one slot to keep the ring compact.
            if (idx_ff + CW'(1) < count_ff) begin
               rd_addr  = oldest_ff + idx_ff[AW-1:0] + AW'(1);
               state_in = S_MVWR;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_MVWR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_ff + CW'(1);
            state_in = S_MVRD;
         end
         S_DONE: begin
            rsp_in.queue_nonempty = (count_ff != '0);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         oldest_ff <= '0;
         count_ff  <= '0;
         bytes_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         bytes_ff  <= bytes_in;
         idx_ff    <= idx_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      len_ff <= len_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(pddq_pkg::QUEUE_DEPTH))
      else $error("entry count above depth");

   a_bytes_bound: assert property (@(posedge clock) disable iff (reset)
      bytes_ff <= BW'(BYTE_LIMIT))
      else $error("queued bytes above limit");

   a_empty_bytes: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> bytes_ff == '0)
      else $error("bytes left in empty queue");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

endmodule

// ===== test/pddq_checker.sv =====
module pddq_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  pddq_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  pddq_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [9:0]        csr_data,
   output int                mismatches,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = pddq_pkg::QUEUE_DEPTH;
   localparam int BYTE_LIMIT = 4194304;
   localparam int CHANNELS   = 16;

   logic [31:0] held_arrival [DEPTH];
   logic [3:0]  held_channel [DEPTH];
   logic [15:0] held_length [DEPTH];
   logic [31:0] held_sender [DEPTH];
   int          head;
   int          held_count;
   longint      held_bytes;
   logic [9:0]  lag_ms;
   logic [6:0]  drop_pct;
   pddq_pkg::rsp_type outcome_q[$];

   function automatic int ring(int i);
      return (head + i) % DEPTH;
   endfunction

   // Works out the response to one request and updates the shadow queue.
   function automatic pddq_pkg::rsp_type predict_outcome(pddq_pkg::req_type r);
      pddq_pkg::rsp_type o;
      logic [6:0]  drop;
      logic [15:0] len;
      logic [31:0] diff;
      int          i;
      int          p;
      o = '0;
      o.status = pddq_pkg::ST_BYPASS;
      drop = (drop_pct > pddq_pkg::MAX_DROP) ? pddq_pkg::MAX_DROP : drop_pct;
      len = r.packet_length;
      if (r.mode == pddq_pkg::MODE_FLUSH) begin
         head = 0;
         held_count = 0;
         held_bytes = 0;
         o.status = pddq_pkg::ST_FLUSHED;
      end else if (r.mode != pddq_pkg::MODE_ARRIVE && r.mode != pddq_pkg::MODE_READ) begin
         o.status = pddq_pkg::ST_BYPASS;
      end else if (lag_ms == 0 && drop == 0) begin
         head = 0;
         held_count = 0;
         held_bytes = 0;
      end else if (r.channel_id >= CHANNELS) begin
         o.status = pddq_pkg::ST_BYPASS;
      end else if (r.mode == pddq_pkg::MODE_ARRIVE) begin
         if (len == 0 || (drop != 0 && r.drop_roll <= drop)) begin
            o.status = pddq_pkg::ST_DROPPED;
         end else begin
            while (held_count > 0 &&
                   (held_count >= DEPTH || held_bytes + len > BYTE_LIMIT)) begin
               held_bytes -= held_length[head];
               head = (head + 1) % DEPTH;
               held_count--;
               o.evicted_count++;
            end
            p = ring(held_count);
            held_arrival[p] = r.now_ms;
            held_channel[p] = r.channel_id;
            held_length[p] = len;
            held_sender[p] = r.sender_tag;
            held_count++;
            held_bytes += len;
            o.slot = p[9:0];
            o.status = pddq_pkg::ST_QUEUED;
         end
      end else begin
         o.status = pddq_pkg::ST_BLOCK;
         for (i = 0; i < held_count; i++) begin
            p = ring(i);
            diff = r.now_ms - held_arrival[p] - 32'(lag_ms);
            if (held_channel[p] == r.channel_id && !diff[31]) begin
               o.slot = p[9:0];
               o.full_length = held_length[p];
               o.sender_tag_out = held_sender[p];
               o.copied_length = (held_length[p] < r.read_capacity) ?
                                 held_length[p] : r.read_capacity;
               o.status = (o.copied_length < o.full_length) ? pddq_pkg::ST_TRUNCATED
                                                            : pddq_pkg::ST_DELIVERED;
               held_bytes -= held_length[p];
               // Younger entries slide down one slot to keep the ring compact.
               for (; i + 1 < held_count; i++) begin
                  held_arrival[ring(i)] = held_arrival[ring(i + 1)];
                  held_channel[ring(i)] = held_channel[ring(i + 1)];
                  held_length[ring(i)] = held_length[ring(i + 1)];
                  held_sender[ring(i)] = held_sender[ring(i + 1)];
               end
               held_count--;
               break;
            end
         end
      end
      o.queue_nonempty = (held_count != 0);
      return o;
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      pddq_pkg::rsp_type want;
      if (reset) begin
         head = 0;
         held_count = 0;
         held_bytes = 0;
         lag_ms = '0;
         drop_pct = '0;
         outcome_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: response with none expected, got %p", $time, rsp_data);
               mismatches++;
            end else begin
               want = outcome_q[0];
               outcome_q.delete(0);
               check_field("status", want.status, rsp_data.status);
               check_field("slot", want.slot, rsp_data.slot);
               check_field("copied_length", want.copied_length, rsp_data.copied_length);
               check_field("full_length", want.full_length, rsp_data.full_length);
               check_field("sender_tag_out", want.sender_tag_out, rsp_data.sender_tag_out);
               check_field("evicted_count", want.evicted_count, rsp_data.evicted_count);
               check_field("queue_nonempty", want.queue_nonempty,
                           rsp_data.queue_nonempty);
            end
         end
         if (csr_write) begin
            if (csr_index == pddq_pkg::CSR_LAG) lag_ms = csr_data;
            else drop_pct = csr_data[6:0];
         end
         if (req_valid && !req_stall) outcome_q = {outcome_q, predict_outcome(req_data)};
      end
      pending = outcome_q.size();
   end

endmodule

// ===== test/tb_packet_delay_drop_queue.sv =====
module tb_packet_delay_drop_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 50000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   pddq_pkg::req_type req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   pddq_pkg::rsp_type rsp_data;
   logic       csr_write;
   logic       csr_index;
   logic [9:0] csr_data;
   int         mismatches;
   int         pending;
   int         idle_cycles;
   int         stall_left;
   bit         no_gaps;
   logic [31:0] clock_ms;
   logic [9:0] lag_now;

   packet_delay_drop_queue uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   pddq_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .mismatches(mismatches), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("packet_delay_drop_queue regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver back-pressure: mostly short stalls, now and then a long one.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall = 1'b1;
      end else if (!no_gaps && $urandom_range(0, 99) < 20) begin
         stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(0, 3);
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic issue(pddq_pkg::req_type r);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_reg(logic idx, logic [9:0] value);
      drain();
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      if (idx == pddq_pkg::CSR_LAG) lag_now = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   function automatic pddq_pkg::req_type build(logic [1:0] mode, logic [31:0] now,
                                               logic [3:0] chan, logic [15:0] len,
                                               logic [6:0] roll, logic [15:0] cap);
      pddq_pkg::req_type r;
      r.mode = mode;
      r.now_ms = now;
      r.channel_id = chan;
      r.packet_length = len;
      r.sender_tag = $urandom;
      r.drop_roll = roll;
      r.read_capacity = cap;
      return r;
   endfunction

   function automatic pddq_pkg::req_type random_item();
      int          m;
      logic [1:0]  mode;
      logic [31:0] now;
      logic [15:0] len;
      logic [6:0]  roll;
      m = $urandom_range(0, 99);
      if (m < 47) mode = pddq_pkg::MODE_ARRIVE;
      else if (m < 95) mode = pddq_pkg::MODE_READ;
      else if (m < 98) mode = pddq_pkg::MODE_FLUSH;
      else mode = pddq_pkg::MODE_RESERVED;
      clock_ms = clock_ms + $urandom_range(0, lag_now / 4 + 12);
      now = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
      len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1500));
      if ($urandom_range(0, 49) == 0) len = 16'd0;
      roll = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 100));
      return build(mode, now, 4'($urandom), len, roll,
                   ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'hFFFF);
   endfunction

   task automatic random_phase(logic [9:0] lag, logic [9:0] drop, int count);
      set_reg(pddq_pkg::CSR_LAG, lag);
      set_reg(pddq_pkg::CSR_DROP, drop);
      no_gaps = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain();
         issue(random_item());
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = pddq_pkg::CSR_LAG;
      csr_data = '0;
      no_gaps = 1'b0;
      lag_now = '0;
      clock_ms = 32'hFFFF_F000;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Both registers zero: requests pass straight through.
      issue(build(pddq_pkg::MODE_ARRIVE, 32'd10, 4'd1, 16'd100, 7'd50, 16'd0));
      issue(build(pddq_pkg::MODE_READ, 32'd20, 4'd1, 16'd0, 7'd1, 16'd100));
      issue(build(pddq_pkg::MODE_FLUSH, 32'd20, 4'd0, 16'd0, 7'd1, 16'd0));

      set_reg(pddq_pkg::CSR_LAG, 10'd5);
      issue(build(pddq_pkg::MODE_ARRIVE, 32'd100, 4'd0, 16'd1, 7'd1, 16'd0));
      issue(build(pddq_pkg::MODE_ARRIVE, 32'd100, 4'd15, 16'hFFFF, 7'd100, 16'd0));
      issue(build(pddq_pkg::MODE_ARRIVE, 32'd100, 4'd3, 16'd0, 7'd100, 16'd0));
      issue(build(pddq_pkg::MODE_READ, 32'd104, 4'd0, 16'd0, 7'd0, 16'd10));
      issue(build(pddq_pkg::MODE_READ, 32'd105, 4'd0, 16'd0, 7'd0, 16'd0));
      issue(build(pddq_pkg::MODE_READ, 32'd200, 4'd15, 16'd0, 7'd0, 16'hFFFF));
      issue(build(pddq_pkg::MODE_READ, 32'd200, 4'd15, 16'd0, 7'd0, 16'hFFFF));
      issue(build(pddq_pkg::MODE_RESERVED, 32'd200, 4'd0, 16'd0, 7'd0, 16'd0));
      // Arrival just before the 32-bit wrap, read just after it.
      issue(build(pddq_pkg::MODE_ARRIVE, 32'hFFFF_FFFE, 4'd9, 16'd700, 7'd1, 16'd0));
      issue(build(pddq_pkg::MODE_READ, 32'd2, 4'd9, 16'd0, 7'd0, 16'd699));
      issue(build(pddq_pkg::MODE_READ, 32'd3, 4'd9, 16'd0, 7'd0, 16'd699));
      issue(build(pddq_pkg::MODE_ARRIVE, 32'd300, 4'd2, 16'd40, 7'd1, 16'd0));
      issue(build(pddq_pkg::MODE_FLUSH, 32'd300, 4'd0, 16'd0, 7'd0, 16'd0));

      set_reg(pddq_pkg::CSR_DROP, 10'd127);
      issue(build(pddq_pkg::MODE_ARRIVE, 32'd400, 4'd4, 16'd64, 7'd100, 16'd0));
      issue(build(pddq_pkg::MODE_ARRIVE, 32'd400, 4'd4, 16'd64, 7'd127, 16'd0));
      set_reg(pddq_pkg::CSR_DROP, 10'd50);
      issue(build(pddq_pkg::MODE_ARRIVE, 32'd400, 4'd4, 16'd64, 7'd50, 16'd0));
      issue(build(pddq_pkg::MODE_ARRIVE, 32'd400, 4'd4, 16'd64, 7'd51, 16'd0));

      // Byte limit: the sixty-fifth maximum-length packet evicts the oldest.
      set_reg(pddq_pkg::CSR_DROP, 10'd0);
      set_reg(pddq_pkg::CSR_LAG, 10'd1);
      for (int i = 0; i < 67; i++)
         issue(build(pddq_pkg::MODE_ARRIVE, 32'd500 + i, 4'(i), 16'hFFFF, 7'd1, 16'd0));
      issue(build(pddq_pkg::MODE_FLUSH, 32'd600, 4'd0, 16'd0, 7'd0, 16'd0));

      // Small packets on random channels, then reads before and after they are due.
      set_reg(pddq_pkg::CSR_LAG, 10'd1023);
      for (int i = 0; i < 40; i++)
         issue(build(pddq_pkg::MODE_ARRIVE, 32'd1000 + i, 4'($urandom),
                     16'($urandom_range(1, 9)), 7'd1, 16'd0));
      drain();
      issue(build(pddq_pkg::MODE_READ, 32'd4000, 4'd7, 16'd0, 7'd0, 16'd5));
      issue(build(pddq_pkg::MODE_READ, 32'd1500, 4'd7, 16'd0, 7'd0, 16'd5));
      issue(build(pddq_pkg::MODE_READ, 32'd9000, 4'd12, 16'd0, 7'd0, 16'hFFFF));
      issue(build(pddq_pkg::MODE_FLUSH, 32'd9000, 4'd0, 16'd0, 7'd0, 16'd0));

      random_phase(10'd20, 10'd0, 90);
      random_phase(10'd1023, 10'd127, 40);
      random_phase(10'd0, 10'd30, 50);
      random_phase(10'd0, 10'd0, 12);
      random_phase(10'($urandom_range(1, 200)), 10'($urandom_range(0, 100)), 80);

      drain();
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("packet_delay_drop_queue regression: pass");
      end else begin
         $display("packet_delay_drop_queue regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/pddq_pkg.sv
src/pddq_store.sv
src/packet_delay_drop_queue.sv
test/pddq_checker.sv
test/tb_packet_delay_drop_queue.sv
